// ===== sv/ssd_pkg.sv =====
package ssd_pkg;

  // Display geometry
  localparam int unsigned DIGIT_COUNT = 3;
  localparam int unsigned SEG_WIDTH   = 8;
  localparam int unsigned SEND_BITS   = DIGIT_COUNT * SEG_WIDTH;
  localparam int unsigned CNT_WIDTH   = $clog2(SEND_BITS + 1);

  // Binary to BCD conversion: values 0..999 need ten bits and three BCD digits
  localparam int unsigned BIN_WIDTH  = 10;
  localparam int unsigned BCD_WIDTH  = 4 * DIGIT_COUNT;
  localparam int unsigned CONV_STEPS = BIN_WIDTH;

  localparam logic signed [15:0] NUMBER_MAX = 16'sd999;

  // Request codes
  localparam logic [2:0] REQ_SHOW_NUMBER = 3'd0;
  localparam logic [2:0] REQ_SHOW_BYTES  = 3'd1;
  localparam logic [2:0] REQ_SET_DIGIT   = 3'd2;
  localparam logic [2:0] REQ_READ_DIGIT  = 3'd3;
  localparam logic [2:0] REQ_REFRESH     = 3'd4;

  // Configuration register indexes
  localparam logic CFG_DP_OVERRIDE = 1'b0;
  localparam logic CFG_DP_BITS     = 1'b1;

  // Fixed messages, digit 0 first
  localparam logic [7:0] MSG_BIG_0 = 8'b0011_1110;
  localparam logic [7:0] MSG_BIG_1 = 8'b0110_0000;
  localparam logic [7:0] MSG_BIG_2 = 8'b1011_1100;
  localparam logic [7:0] MSG_NEG_0 = 8'b1110_1100;
  localparam logic [7:0] MSG_NEG_1 = 8'b1101_1110;
  localparam logic [7:0] MSG_NEG_2 = 8'b1111_0110;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD,
    ST_SEND,
    ST_READ
  } state_t;

  // Segment code of one decimal digit, ABCDEFG in bits 7..1, dp clear
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'hFC;
      4'd1: code = 8'h60;
      4'd2: code = 8'hDA;
      4'd3: code = 8'hF2;
      4'd4: code = 8'h66;
      4'd5: code = 8'hB6;
      4'd6: code = 8'hBE;
      4'd7: code = 8'hE0;
      4'd8: code = 8'hFE;
      4'd9: code = 8'hF6;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/ssd_req_if.sv =====
interface ssd_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] number_value;
  logic [7:0]         byte_left;
  logic [7:0]         byte_mid;
  logic [7:0]         byte_right;
  logic [2:0]         digit_pos;

  modport source (
    output valid, req_type, number_value, byte_left, byte_mid, byte_right, digit_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, number_value, byte_left, byte_mid, byte_right, digit_pos,
    output ready
  );
endinterface

// ===== sv/ssd_res_if.sv =====
interface ssd_res_if;
  logic       valid;
  logic       ready;
  logic       serial_bit;
  logic       is_read;
  logic [7:0] read_byte;
  logic       last;

  modport source (
    output valid, serial_bit, is_read, read_byte, last,
    input  ready
  );
  modport sink (
    input  valid, serial_bit, is_read, read_byte, last,
    output ready
  );
endinterface

// ===== sv/seven_segment_number_shift_driver_unit.sv =====
// Three-digit seven-segment driver feeding a chained shift register.
// Channels: req (sink) takes one request per transaction; res (source) gives
// one result per transaction, each carrying one shift-clock data bit, or the
// read data of a read-digit request. cfg_we/cfg_index/cfg_data write the
// decimal-point override registers; write them only while the block is idle.
// Request sequences:
//   show bytes, set digit, refresh: a load, then 24 results, one bit a
//     cycle from the output shift register while the receiver is ready.
//   show number in 0..999: bit-serial binary to BCD conversion first,
//     then the load and the 24 results.
//   read digit: one result. Unused codes and set digit at an
//     invalid position are dropped with no result.
// The 24-bit output shift register sets the rate, one bit per unstalled cycle.
// Reset clears the stored digits, the decimal-point override registers, the
// sequencer and the result valid flag. When the receiver stalls, the current
// result holds in the result register and the shift sequence pauses; a new
// request is accepted while the final result of the previous one still waits.
module seven_segment_number_shift_driver_unit
  import ssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ssd_req_if.sink    req,
  ssd_res_if.source  res,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  state_t state, state_next;

  logic [7:0]             digit_store [DIGIT_COUNT];
  logic                   dp_override;
  logic [DIGIT_COUNT-1:0] dp_bits;

  logic [SEND_BITS-1:0]   shift_reg;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [BIN_WIDTH-1:0]   bin_reg;
  logic [BCD_WIDTH-1:0]   bcd_reg;
  logic [7:0]             rd_byte;

  logic                   out_valid;
  logic                   out_serial;
  logic                   out_is_read;
  logic [7:0]             out_read_byte;
  logic                   out_last;

  logic                   out_free;
  logic                   out_load;
  logic                   req_fire;
  logic                   pos_valid;
  logic                   num_big;
  logic                   num_neg;
  logic                   conv_done;
  logic                   send_done;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [BCD_WIDTH-1:0]   bcd_next;
  logic [SEND_BITS-1:0]   load_word;

  assign out_free  = !out_valid || res.ready;
  assign req_fire  = req.valid && req.ready;
  assign pos_valid = req.digit_pos < 3'(DIGIT_COUNT);
  assign num_big   = req.number_value > NUMBER_MAX;
  assign num_neg   = req.number_value < 16'sd0;
  assign conv_done = cnt == CNT_WIDTH'(CONV_STEPS - 1);
  assign send_done = cnt == CNT_WIDTH'(SEND_BITS - 1);

  // Double dabble step: adjust each BCD digit, then shift in the next binary bit
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                      : bcd_reg[4*i +: 4];
    end
    bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[BIN_WIDTH-1]};
  end

  // Build the send word: digit 2 in the low byte so it leaves first, LSB first
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      load_word[(DIGIT_COUNT-1-d)*SEG_WIDTH +: SEG_WIDTH] =
        {digit_store[d][7:1], dp_override ? dp_bits[d] : digit_store[d][0]};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.req_type)
            REQ_SHOW_NUMBER: state_next = (num_big || num_neg) ? ST_LOAD : ST_CONV;
            REQ_SHOW_BYTES:  state_next = ST_LOAD;
            REQ_SET_DIGIT:   state_next = pos_valid ? ST_LOAD : ST_IDLE;
            REQ_READ_DIGIT:  state_next = ST_READ;
            REQ_REFRESH:     state_next = ST_LOAD;
            default:         state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_SEND;
      ST_SEND: begin
        if (out_free && send_done) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and result register control
  always_comb begin
    req.ready = state == ST_IDLE;
    out_load  = (state == ST_SEND || state == ST_READ) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dp_override <= 1'b0;
      dp_bits     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DP_OVERRIDE: dp_override <= cfg_data[0];
        CFG_DP_BITS:     dp_bits     <= cfg_data[DIGIT_COUNT-1:0];
        default:         dp_override <= dp_override;
      endcase
    end
  end

  // Digit store: written on accepted requests and at the end of a conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DIGIT_COUNT; d++) digit_store[d] <= '0;
    end else if (req_fire) begin
      case (req.req_type)
        REQ_SHOW_NUMBER: begin
          if (num_big) begin
            digit_store[0] <= MSG_BIG_0;
            digit_store[1] <= MSG_BIG_1;
            digit_store[2] <= MSG_BIG_2;
          end else if (num_neg) begin
            digit_store[0] <= MSG_NEG_0;
            digit_store[1] <= MSG_NEG_1;
            digit_store[2] <= MSG_NEG_2;
          end
        end
        REQ_SHOW_BYTES: begin
          digit_store[0] <= req.byte_left;
          digit_store[1] <= req.byte_mid;
          digit_store[2] <= req.byte_right;
        end
        REQ_SET_DIGIT: begin
          if (pos_valid) digit_store[req.digit_pos[1:0]] <= req.byte_left;
        end
        default: digit_store[0] <= digit_store[0];
      endcase
    end else if (state == ST_CONV && conv_done) begin
      // Hundreds go to the leftmost digit
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        digit_store[d] <= seg_code(bcd_next[4*(DIGIT_COUNT-1-d) +: 4]);
      end
    end
  end

  // Conversion, shift and count datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt     <= '0;
        bin_reg <= req.number_value[BIN_WIDTH-1:0];
        bcd_reg <= '0;
        rd_byte <= pos_valid ? digit_store[req.digit_pos[1:0]] : 8'h00;
      end
      ST_CONV: begin
        bcd_reg <= bcd_next;
        bin_reg <= {bin_reg[BIN_WIDTH-2:0], 1'b0};
        cnt     <= cnt + CNT_WIDTH'(1);
      end
      ST_LOAD: begin
        shift_reg <= load_word;
        cnt       <= '0;
      end
      ST_SEND: begin
        if (out_free) begin
          shift_reg <= {1'b0, shift_reg[SEND_BITS-1:1]};
          cnt       <= cnt + CNT_WIDTH'(1);
        end
      end
      default: cnt <= cnt;
    endcase
  end

  // Result register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_READ) begin
        out_serial    <= 1'b0;
        out_is_read   <= 1'b1;
        out_read_byte <= rd_byte;
        out_last      <= 1'b1;
      end else begin
        out_serial    <= shift_reg[0];
        out_is_read   <= 1'b0;
        out_read_byte <= 8'h00;
        out_last      <= send_done;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.serial_bit = out_serial;
  assign res.is_read    = out_is_read;
  assign res.read_byte  = out_read_byte;
  assign res.last       = out_last;

endmodule
